@@ sv/irq_least_count_balancer_assert.svh @@
// ----------------------------------------------------------------------------
// irq_least_count_balancer_assert.svh
// Assertion macros shared by the checker of the interrupt balancer.
// ----------------------------------------------------------------------------
`ifndef IRQ_LEAST_COUNT_BALANCER_ASSERT_SVH
`define IRQ_LEAST_COUNT_BALANCER_ASSERT_SVH

// Consequent must hold in the cycle after the antecedent.
`define ILCB_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define ILCB_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

@@ sv/ilcb_pkg.sv @@
// ----------------------------------------------------------------------------
// ilcb_pkg
// Shared constants and types of the interrupt count balancer.
// ----------------------------------------------------------------------------
package ilcb_pkg;

    // Field widths of the input and result words.
    localparam int CORE_ID_W  = 4;
    localparam int IRQ_W      = 4;
    localparam int S_TDATA_W  = 16;
    localparam int M_TDATA_W  = 16;

    // Configuration port.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int ACTIVE_W   = 5;
    localparam int DIVISOR_W  = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_SYM_IO   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BAL_EN   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DIVISOR  = 2'd3;

    localparam logic [ACTIVE_W-1:0]  ACTIVE_RESET  = 5'd1;
    localparam logic [DIVISOR_W-1:0] DIVISOR_RESET = 16'd10;

    // Status of the remainder unit.
    typedef struct packed {
        logic done;
        logic rem_zero;
    } rem_stat_t;

endpackage

@@ sv/ilcb_rem_unit.sv @@
// ----------------------------------------------------------------------------
// ilcb_rem_unit
// Bit-serial restoring remainder of a count by the balancing divisor.
// ----------------------------------------------------------------------------
module ilcb_rem_unit #(
    parameter int COUNT_BITS = 32
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic [COUNT_BITS-1:0]           dividend,
    input  logic [ilcb_pkg::DIVISOR_W-1:0]  divisor,
    output ilcb_pkg::rem_stat_t             stat
);
    import ilcb_pkg::*;

    localparam int STEP_W = $clog2(COUNT_BITS + 1);

    logic                  busy_reg;
    logic                  done_reg;
    logic [STEP_W-1:0]     step_reg;
    logic [COUNT_BITS-1:0] shift_reg;
    logic [DIVISOR_W-1:0]  rem_reg;
    logic [DIVISOR_W:0]    trial;
    logic [DIVISOR_W:0]    rem_next;

    // One quotient bit per cycle; the partial remainder stays below twice
    // the divisor, so one compare and subtract restores it.
    always_comb
    begin
        trial = {rem_reg, shift_reg[COUNT_BITS-1]};
        if (trial >= {1'b0, divisor})
        begin
            rem_next = trial - {1'b0, divisor};
        end
        else
        begin
            rem_next = trial;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg  <= 1'b1;
                step_reg  <= STEP_W'(COUNT_BITS);
                shift_reg <= dividend;
                rem_reg   <= '0;
            end
            else if (busy_reg)
            begin
                rem_reg   <= rem_next[DIVISOR_W-1:0];
                shift_reg <= {shift_reg[COUNT_BITS-2:0], 1'b0};
                step_reg  <= step_reg - 1'b1;
                if (step_reg == STEP_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign stat.done     = done_reg;
    assign stat.rem_zero = (rem_reg == '0);

endmodule

@@ sv/irq_least_count_balancer.sv @@
// ----------------------------------------------------------------------------
// irq_least_count_balancer
// Per-core interrupt counting with least-loaded interrupt routing.
// ----------------------------------------------------------------------------
// Usage: each word on the s_ stream reports one serviced interrupt (core,
// irq, balancing allowed). Exactly one word per input comes out on the m_
// stream: the end-of-interrupt target and irq, and, when a balancing pass
// ran, the core with the fewest counts for that irq and whether the irq's
// counts were cleared. The cfg_ port writes the four registers; it must be
// used only while the block is idle; the block itself does not enforce this.
// Operation: an in-range item goes through the read, increment and result
// states; an out-of-range core or irq goes straight to the result. An item
// that may be balanced adds the bit-serial remainder check; a balancing pass
// adds the scan over the active cores (one count read per cycle from the
// count memory), and, when the counts are cleared, one memory write per
// core. One item is in work at a time; the next one is taken as soon as the
// result is registered.
// Reset: the count memory is zeroed by a sweep of one entry per cycle over
// all 2**(CORE_W+LINE_W) entries (256 with the defaults), during which
// s_tready stays low. Registers return to their reset values at once.
// Stall: the result waits in the output register while m_tready is low;
// a new input may still be taken and worked on, and its result waits for
// the register to empty.
// ----------------------------------------------------------------------------
module irq_least_count_balancer #(
    parameter int MAX_CORES  = 16,
    parameter int IRQ_LINES  = 16,
    parameter int COUNT_BITS = 32
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // Fields from bit 0: core_id[3:0], irq[7:4], balance_allowed[8], zero.
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [ilcb_pkg::S_TDATA_W-1:0]   s_tdata,
    // Fields from bit 0: eoi_to_local_apic[0], eoi_irq[4:1], route_valid[5],
    // route_irq[9:6], route_core[13:10], counts_cleared[14], zero.
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [ilcb_pkg::M_TDATA_W-1:0]   m_tdata,
    input  logic                             cfg_we,
    input  logic [ilcb_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [ilcb_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import ilcb_pkg::*;

    localparam int CORE_W = (MAX_CORES > 1) ? $clog2(MAX_CORES) : 1;
    localparam int LINE_W = (IRQ_LINES > 1) ? $clog2(IRQ_LINES) : 1;
    localparam int ADDR_W = CORE_W + LINE_W;
    localparam int DEPTH  = 1 << ADDR_W;
    localparam int SCAN_W = $clog2(MAX_CORES + 1);
    localparam int CMP_W  = 7;

    typedef enum logic [2:0] {
        ST_SWEEP,
        ST_IDLE,
        ST_READ,
        ST_INC,
        ST_DIV,
        ST_SCAN,
        ST_CLR,
        ST_FIN
    } state_t;

    // Configuration registers.
    logic                 sym_io_reg;
    logic                 bal_en_reg;
    logic [ACTIVE_W-1:0]  active_reg;
    logic [DIVISOR_W-1:0] divisor_reg;

    // Control and item registers.
    state_t               state_reg;
    logic [ADDR_W-1:0]    sweep_reg;
    logic [CORE_W-1:0]    core_idx_reg;
    logic [LINE_W-1:0]    line_idx_reg;
    logic [IRQ_W-1:0]     irq_reg;
    logic                 allowed_reg;
    logic                 route_reg;
    logic                 clear_reg;
    logic [SCAN_W-1:0]    idx_reg;
    logic                 pend_reg;
    logic [CORE_W-1:0]    cmp_idx_reg;
    logic [COUNT_BITS-1:0] min_reg;
    logic [CORE_W-1:0]    min_core_reg;
    logic                 m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;

    // Count memory.
    logic [COUNT_BITS-1:0] mem [DEPTH];
    logic [COUNT_BITS-1:0] rdata_reg;
    logic                  mem_we;
    logic [ADDR_W-1:0]     mem_waddr;
    logic [COUNT_BITS-1:0] mem_wdata;
    logic [ADDR_W-1:0]     mem_raddr;

    logic [CORE_ID_W-1:0]  in_core;
    logic [IRQ_W-1:0]      in_irq;
    logic                  in_allowed;
    logic                  in_range;
    logic                  s_accept;
    logic [COUNT_BITS-1:0] cnt_inc;
    logic                  bal_go;
    logic [SCAN_W-1:0]     n_scan;
    logic [CORE_W-1:0]     idx_core;
    logic                  div_start;
    rem_stat_t             div_stat;
    logic [M_TDATA_W-1:0]  result_word;

    assign in_core    = s_tdata[CORE_ID_W-1:0];
    assign in_irq     = s_tdata[CORE_ID_W+IRQ_W-1:CORE_ID_W];
    assign in_allowed = s_tdata[CORE_ID_W+IRQ_W];
    assign in_range   = ({3'b000, in_core} < CMP_W'(MAX_CORES))
                     && ({3'b000, in_irq} < CMP_W'(IRQ_LINES));

    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;

    // The increment wraps at the counter width by truncation.
    assign cnt_inc = rdata_reg + 1'b1;
    assign bal_go  = bal_en_reg && allowed_reg && (cnt_inc != '0) && (divisor_reg != '0);

    // Cores scanned: the active count, limited to the cores present.
    assign n_scan = ({2'b00, active_reg} > CMP_W'(MAX_CORES)) ? SCAN_W'(MAX_CORES)
                                                               : SCAN_W'(active_reg);
    assign idx_core  = CORE_W'(idx_reg);
    assign div_start = (state_reg == ST_INC) && bal_go;

    ilcb_rem_unit #(
        .COUNT_BITS (COUNT_BITS)
    ) u_rem (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (cnt_inc),
        .divisor  (divisor_reg),
        .stat     (div_stat)
    );

    // Memory port selection. Reads and writes of one item never overlap:
    // each access to an entry is at least one state after the last write.
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = {core_idx_reg, line_idx_reg};
        mem_wdata = '0;
        unique case (state_reg)
            ST_SWEEP:
            begin
                mem_we    = 1'b1;
                mem_waddr = sweep_reg;
            end
            ST_INC:
            begin
                mem_we    = 1'b1;
                mem_wdata = cnt_inc;
            end
            ST_CLR:
            begin
                mem_we    = 1'b1;
                mem_waddr = {idx_core, line_idx_reg};
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
        if (state_reg == ST_SCAN)
        begin
            mem_raddr = {idx_core, line_idx_reg};
        end
        else
        begin
            mem_raddr = {core_idx_reg, line_idx_reg};
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rdata_reg <= mem[mem_raddr];
    end

    // Route fields read zero when no balancing pass ran.
    always_comb
    begin
        result_word        = '0;
        result_word[0]     = sym_io_reg;
        result_word[4:1]   = irq_reg;
        result_word[5]     = route_reg;
        result_word[9:6]   = route_reg ? irq_reg : '0;
        result_word[13:10] = route_reg ? 4'(min_core_reg) : '0;
        result_word[14]    = route_reg && clear_reg;
    end

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sym_io_reg  <= 1'b0;
            bal_en_reg  <= 1'b0;
            active_reg  <= ACTIVE_RESET;
            divisor_reg <= DIVISOR_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_SYM_IO:  sym_io_reg  <= cfg_data[0];
                CFG_BAL_EN:  bal_en_reg  <= cfg_data[0];
                CFG_ACTIVE:  active_reg  <= cfg_data[ACTIVE_W-1:0];
                CFG_DIVISOR: divisor_reg <= cfg_data[DIVISOR_W-1:0];
            endcase
        end
    end

    // Sequencer: sweep after reset, then read, increment, optional
    // remainder check, optional scan for the minimum, optional clear, result.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_SWEEP;
            sweep_reg    <= '0;
            m_tvalid_reg <= 1'b0;
            pend_reg     <= 1'b0;
            idx_reg      <= '0;
        end
        else
        begin
            // In ST_FIN the new word takes the place of the one leaving.
            if (m_tvalid_reg && m_tready && (state_reg != ST_FIN))
            begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_SWEEP:
                begin
                    sweep_reg <= sweep_reg + 1'b1;
                    if (sweep_reg == ADDR_W'(DEPTH - 1))
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE:
                begin
                    if (s_accept)
                    begin
                        core_idx_reg <= CORE_W'(in_core);
                        line_idx_reg <= LINE_W'(in_irq);
                        irq_reg      <= in_irq;
                        allowed_reg  <= in_allowed;
                        route_reg    <= 1'b0;
                        clear_reg    <= 1'b0;
                        state_reg    <= in_range ? ST_READ : ST_FIN;
                    end
                end
                ST_READ:
                begin
                    state_reg <= ST_INC;
                end
                ST_INC:
                begin
                    state_reg <= bal_go ? ST_DIV : ST_FIN;
                end
                ST_DIV:
                begin
                    if (div_stat.done)
                    begin
                        if (div_stat.rem_zero)
                        begin
                            route_reg    <= 1'b1;
                            min_reg      <= '1;
                            min_core_reg <= '0;
                            idx_reg      <= '0;
                            pend_reg     <= 1'b0;
                            state_reg    <= ST_SCAN;
                        end
                        else
                        begin
                            state_reg <= ST_FIN;
                        end
                    end
                end
                ST_SCAN:
                begin
                    // Compare the count read in the previous cycle.
                    if (pend_reg)
                    begin
                        if (rdata_reg < min_reg)
                        begin
                            min_reg      <= rdata_reg;
                            min_core_reg <= cmp_idx_reg;
                        end
                        else if (&rdata_reg[COUNT_BITS-1:1])
                        begin
                            clear_reg <= 1'b1;
                        end
                    end
                    // Issue the next read.
                    if (idx_reg < n_scan)
                    begin
                        idx_reg     <= idx_reg + 1'b1;
                        cmp_idx_reg <= idx_core;
                        pend_reg    <= 1'b1;
                    end
                    else
                    begin
                        pend_reg <= 1'b0;
                    end
                    if (!pend_reg && (idx_reg >= n_scan))
                    begin
                        idx_reg   <= '0;
                        state_reg <= clear_reg ? ST_CLR : ST_FIN;
                    end
                end
                ST_CLR:
                begin
                    idx_reg <= idx_reg + 1'b1;
                    if (SCAN_W'(idx_reg + 1'b1) == n_scan)
                    begin
                        state_reg <= ST_FIN;
                    end
                end
                ST_FIN:
                begin
                    if (!m_tvalid_reg || m_tready)
                    begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= result_word;
                        state_reg    <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

@@ sv/ilcb_checker.sv @@
// ----------------------------------------------------------------------------
// ilcb_checker
// Port-level checks of the interrupt count balancer, bound to the top level.
// ----------------------------------------------------------------------------
`include "irq_least_count_balancer_assert.svh"

module ilcb_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic [ilcb_pkg::S_TDATA_W-1:0]  s_tdata,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [ilcb_pkg::M_TDATA_W-1:0]  m_tdata
);
    import ilcb_pkg::*;

    logic out_stall;
    logic out_route;
    logic out_plain;

    assign out_stall = m_tvalid && !m_tready;
    assign out_route = m_tvalid && m_tdata[5];
    assign out_plain = m_tvalid && !m_tdata[5];

    // A stalled result holds its word.
    `ILCB_ASSERT_NEXT(a_out_hold, out_stall, m_tvalid && $stable(m_tdata), "held word changed")
    // One item is in work at a time; the block is busy right after an accept.
    `ILCB_ASSERT_NEXT(a_one_item, s_tvalid && s_tready, !s_tready, "input taken while busy")
    // Without a routing decision, the route fields read zero.
    `ILCB_ASSERT_NOW(a_no_route_zero, out_plain, m_tdata[14:6] == 9'd0, "stray route fields")
    // A routing decision re-routes the irq that was serviced.
    `ILCB_ASSERT_NOW(a_route_irq, out_route, m_tdata[9:6] == m_tdata[4:1], "route irq differs")

endmodule

bind irq_least_count_balancer ilcb_checker u_ilcb_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

@@ tb/irq_least_count_balancer_tb.sv @@
// ----------------------------------------------------------------------------
// irq_least_count_balancer_tb
// Self-checking bench for the interrupt count balancer. It streams serviced
// interrupt words into the block, keeps its own copy of the per-core counts
// and the four registers, and checks every end-of-interrupt and routing word
// that comes back, under random gaps and stalls on both streams.
// ----------------------------------------------------------------------------
module irq_least_count_balancer_tb;

    import ilcb_pkg::*;

    // Block parameters, kept at their defaults.
    localparam int MAX_CORES  = 16;
    localparam int IRQ_LINES  = 16;
    localparam int COUNT_BITS = 32;

    // A count at or above this value during a scan wipes the irq's counts.
    localparam bit [COUNT_BITS-1:0] COUNT_MAX  = '1;
    localparam bit [COUNT_BITS-1:0] COUNT_WIPE = COUNT_MAX - 1;

    localparam int CYCLE_LIMIT = 1000000;
    // Cycles left for the block to settle after the last word came out.
    localparam int END_MARGIN  = 100;
    // Length of the long result stall, in cycles.
    localparam int LONG_STALL  = 400;

    // One expected result word, in the order of the m_tdata fields.
    typedef struct {
        bit             eoi_apic;
        bit [IRQ_W-1:0] eoi_irq;
        bit             route_valid;
        bit [IRQ_W-1:0] route_irq;
        bit [3:0]       route_core;
        bit             cleared;
    } eoi_route_t;

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // Bench copy of the block state: counts indexed [core][irq] and registers.
    bit [COUNT_BITS-1:0] irq_counts [MAX_CORES][IRQ_LINES];
    bit                  sym_io_mode;
    bit                  balance_on;
    bit [ACTIVE_W-1:0]   active_cores;
    bit [DIVISOR_W-1:0]  balance_div;

    // Expected result words, oldest first.
    eoi_route_t expected_words [$];

    int unsigned mismatch_count;
    int unsigned words_sent;
    int unsigned words_checked;
    int unsigned routes_seen;
    int unsigned reg_writes;
    int unsigned cycle_count;

    // Idling controls of the stimulus and the result sink.
    bit feed_eager;
    bit sink_eager;
    int sink_hold;

    irq_least_count_balancer #(
        .MAX_CORES  (MAX_CORES),
        .IRQ_LINES  (IRQ_LINES),
        .COUNT_BITS (COUNT_BITS)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        // Fields from bit 0: core_id[3:0], irq[7:4], balance_allowed[8], zero.
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        // Fields from bit 0: eoi_to_local_apic[0], eoi_irq[4:1], route_valid[5],
        // route_irq[9:6], route_core[13:10], counts_cleared[14], zero.
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d words still expected",
                     cycle_count, expected_words.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    // Prints one line per mismatch and counts them all.
    task automatic report_mismatch(input string field, input int unsigned got,
                                   input int unsigned want);
        mismatch_count++;
        $display("Mismatch on result word %0d, %s: got %0d, expected %0d",
                 words_checked, field, got, want);
    endtask

    // Applies one serviced interrupt to the bench counts and works out the
    // word the block must return for it. The count for (core, irq) is bumped
    // first; a balancing pass then runs only when it is enabled, allowed for
    // this handler and the new count is a nonzero multiple of the divisor.
    task automatic count_and_route(input bit [CORE_ID_W-1:0] core,
                                   input bit [IRQ_W-1:0] irq, input bit allowed,
                                   output eoi_route_t word);
        bit [COUNT_BITS-1:0] fresh;
        bit [COUNT_BITS-1:0] lowest;
        bit [COUNT_BITS-1:0] seen;
        int                  scan_len;
        int                  lowest_core;
        bit                  wipe;

        word = '{default: 0};
        word.eoi_apic = sym_io_mode;
        word.eoi_irq  = irq;

        fresh = irq_counts[core][irq] + 1'b1;
        irq_counts[core][irq] = fresh;

        if (!balance_on || !allowed || fresh == 0 || balance_div == 0 ||
            (fresh % balance_div) != 0)
            return;

        // A register value above the core count scans every core; zero scans
        // none, which leaves core 0 as the target.
        scan_len    = (active_cores > MAX_CORES) ? MAX_CORES : active_cores;
        lowest      = COUNT_MAX;
        lowest_core = 0;
        wipe        = 1'b0;
        for (int i = 0; i < scan_len; i++)
        begin
            seen = irq_counts[i][irq];
            if (seen < lowest)
            begin
                lowest      = seen;
                lowest_core = i;
            end
            else if (seen >= COUNT_WIPE)
                wipe = 1'b1;
        end
        if (wipe)
            for (int i = 0; i < scan_len; i++)
                irq_counts[i][irq] = '0;

        word.route_valid = 1'b1;
        word.route_irq   = irq;
        word.route_core  = lowest_core[3:0];
        word.cleared     = wipe;
    endtask

    // Writes one register; called at a falling edge while the block is idle.
    // The bench copy keeps only the bits the register holds.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] index,
                             input int unsigned value);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value[CFG_DATA_W-1:0];
        case (index)
            CFG_SYM_IO:  sym_io_mode  = value[0];
            CFG_BAL_EN:  balance_on   = value[0];
            CFG_ACTIVE:  active_cores = value[ACTIVE_W-1:0];
            CFG_DIVISOR: balance_div  = value[DIVISOR_W-1:0];
            default: ;
        endcase
        reg_writes++;
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    // Offers one interrupt word after a random gap and waits until the block
    // takes it. tvalid stays high on return so that back-to-back words need
    // no second assignment in the same step.
    task automatic send_word(input bit [CORE_ID_W-1:0] core,
                             input bit [IRQ_W-1:0] irq, input bit allowed);
        int                   gap;
        logic [S_TDATA_W-1:0] word;
        eoi_route_t           want;

        gap = feed_eager ? 0 : $urandom_range(0, 14);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        word      = '0;
        word[8:0] = {allowed, irq, core};
        s_tvalid <= 1'b1;
        s_tdata  <= word;
        do
            @(posedge clk);
        while (!s_tready);
        count_and_route(core, irq, allowed, want);
        expected_words.push_back(want);
        words_sent++;
        @(negedge clk);
    endtask

    // Stops offering words and waits until every expected word came back,
    // so that the registers may be written safely afterwards.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (expected_words.size() != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Result sink: before each word it stalls for a random number of cycles,
    // or for a requested long hold, then keeps tready high until a word moves.
    initial
    begin : result_sink
        int pause;

        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            if (sink_hold > 0)
            begin
                pause     = sink_hold;
                sink_hold = 0;
            end
            else if (sink_eager)
                pause = 0;
            else
                pause = $urandom_range(0, 14);
            if (pause > 0)
            begin
                m_tready <= 1'b0;
                repeat (pause) @(negedge clk);
            end
            m_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_tvalid);
            @(negedge clk);
        end
    end

    // Compares each word taken from the block with the oldest expectation.
    always @(posedge clk)
    begin : check_words
        eoi_route_t want;

        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_words.size() == 0)
                report_mismatch("word with none expected", m_tdata, 0);
            else
            begin
                want = expected_words.pop_front();
                if (m_tdata[0] !== want.eoi_apic)
                    report_mismatch("eoi_to_local_apic", m_tdata[0], want.eoi_apic);
                if (m_tdata[4:1] !== want.eoi_irq)
                    report_mismatch("eoi_irq", m_tdata[4:1], want.eoi_irq);
                if (m_tdata[5] !== want.route_valid)
                    report_mismatch("route_valid", m_tdata[5], want.route_valid);
                if (m_tdata[9:6] !== want.route_irq)
                    report_mismatch("route_irq", m_tdata[9:6], want.route_irq);
                if (m_tdata[13:10] !== want.route_core)
                    report_mismatch("route_core", m_tdata[13:10], want.route_core);
                if (m_tdata[14] !== want.cleared)
                    report_mismatch("counts_cleared", m_tdata[14], want.cleared);
                if (want.route_valid)
                    routes_seen++;
            end
            words_checked++;
        end
    end

    // With the reset settings the end-of-interrupt goes to the PIC and no
    // routing is ever issued; the field extremes go through here.
    task automatic test_reset_defaults();
        send_word(4'd0, 4'd0, 1'b0);
        send_word(4'd15, 4'd15, 1'b1);
        send_word(4'd0, 4'd15, 1'b1);
        send_word(4'd15, 4'd0, 1'b0);
        drain_results();
    endtask

    // The mode register steers the end-of-interrupt to the local APIC.
    task automatic test_eoi_target();
        write_reg(CFG_SYM_IO, 1);
        send_word(4'd10, 4'd5, 1'b1);
        send_word(4'd5, 4'd10, 1'b0);
        drain_results();
    endtask

    // Divisor 1 balances on every allowed word, so the first core holding
    // the lowest count for the irq shows up in each result; words that do
    // not allow balancing only count.
    task automatic test_least_loaded_choice();
        write_reg(CFG_BAL_EN, 1);
        write_reg(CFG_DIVISOR, 1);
        write_reg(CFG_ACTIVE, MAX_CORES);
        send_word(4'd15, 4'd3, 1'b1);
        send_word(4'd0, 4'd3, 1'b1);
        send_word(4'd1, 4'd3, 1'b0);
        send_word(4'd2, 4'd3, 1'b1);
        send_word(4'd1, 4'd3, 1'b1);
        send_word(4'd7, 4'd12, 1'b1);
        drain_results();
    endtask

    // No active core routes to core 0; a value past the core count scans all.
    task automatic test_active_core_extremes();
        write_reg(CFG_SYM_IO, 0);
        write_reg(CFG_ACTIVE, 0);
        send_word(4'd9, 4'd9, 1'b1);
        drain_results();
        write_reg(CFG_ACTIVE, (1 << ACTIVE_W) - 1);
        send_word(4'd0, 4'd9, 1'b1);
        drain_results();
        write_reg(CFG_ACTIVE, 1);
        send_word(4'd4, 4'd9, 1'b1);
        drain_results();
    endtask

    // A zero divisor never balances; the largest one is out of reach here;
    // divisor 2 balances on every second word of a (core, irq) pair.
    task automatic test_divisor_extremes();
        write_reg(CFG_ACTIVE, 8);
        write_reg(CFG_DIVISOR, 0);
        send_word(4'd3, 4'd7, 1'b1);
        send_word(4'd3, 4'd7, 1'b1);
        drain_results();
        write_reg(CFG_DIVISOR, (1 << DIVISOR_W) - 1);
        send_word(4'd3, 4'd7, 1'b1);
        drain_results();
        write_reg(CFG_DIVISOR, 2);
        send_word(4'd6, 4'd7, 1'b1);
        send_word(4'd6, 4'd7, 1'b1);
        drain_results();
    endtask

    // The sink holds off for a long stretch while words keep coming with no
    // gaps, so the block fills its output register and drops s_tready.
    task automatic test_backpressure();
        write_reg(CFG_DIVISOR, 3);
        write_reg(CFG_ACTIVE, MAX_CORES);
        sink_hold  = LONG_STALL;
        feed_eager = 1'b1;
        for (int k = 0; k < 30; k++)
            send_word(CORE_ID_W'($urandom_range(0, 15)), IRQ_W'($urandom_range(4, 5)),
                      $urandom_range(0, 3) != 0);
        feed_eager = 1'b0;
        drain_results();
    endtask

    // Random phases, each with fresh settings. Most words hit one or two irq
    // lines so counts climb and balancing passes happen often; the divisor
    // stays small most of the time for the same reason. One phase runs
    // with no idling on either side.
    task automatic test_random_settings(input int phases, input int per_phase);
        bit [IRQ_W-1:0]     focus;
        bit [IRQ_W-1:0]     irq;
        bit [ACTIVE_W-1:0]  act;
        bit [DIVISOR_W-1:0] div;

        for (int p = 0; p < phases; p++)
        begin
            feed_eager = (p == 2);
            sink_eager = (p == 2);
            case ($urandom_range(0, 9))
                0:       act = 0;
                1:       act = ACTIVE_W'($urandom_range(MAX_CORES + 1, (1 << ACTIVE_W) - 1));
                default: act = ACTIVE_W'($urandom_range(1, MAX_CORES));
            endcase
            case ($urandom_range(0, 11))
                0:       div = 0;
                1:       div = '1;
                2, 3:    div = DIVISOR_W'($urandom_range(5, 40));
                default: div = DIVISOR_W'($urandom_range(1, 4));
            endcase
            write_reg(CFG_SYM_IO, $urandom_range(0, 1));
            write_reg(CFG_BAL_EN, $urandom_range(0, 5) != 0);
            write_reg(CFG_ACTIVE, act);
            write_reg(CFG_DIVISOR, div);
            focus = IRQ_W'($urandom_range(0, 15));
            for (int k = 0; k < per_phase; k++)
            begin
                if ($urandom_range(0, 3) != 0)
                    irq = focus ^ IRQ_W'($urandom_range(0, 1));
                else
                    irq = IRQ_W'($urandom_range(0, 15));
                send_word(CORE_ID_W'($urandom_range(0, 15)), irq,
                          $urandom_range(0, 4) != 0);
            end
            drain_results();
        end
        feed_eager = 1'b0;
        sink_eager = 1'b0;
    endtask

    initial
    begin
        // Every block input is known from time zero on.
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        m_tready  = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        sink_hold = 0;

        // Reset state of the bench copy matches the block after reset.
        foreach (irq_counts[c, i])
            irq_counts[c][i] = '0;
        sym_io_mode  = 1'b0;
        balance_on   = 1'b0;
        active_cores = ACTIVE_RESET;
        balance_div  = DIVISOR_RESET;

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_reset_defaults();
        test_eoi_target();
        test_least_loaded_choice();
        test_active_core_extremes();
        test_divisor_extremes();
        test_backpressure();
        test_random_settings(7, 210);

        drain_results();
        repeat (END_MARGIN) @(posedge clk);
        if (expected_words.size() != 0)
            report_mismatch("words never returned", 0, expected_words.size());

        $display("Run covered %0d interrupt words and %0d register writes;",
                 words_sent, reg_writes);
        $display("%0d result words checked, %0d of them carried a routing decision.",
                 words_checked, routes_seen);
        if (mismatch_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+sv
sv/ilcb_pkg.sv
sv/ilcb_rem_unit.sv
sv/irq_least_count_balancer.sv
sv/ilcb_checker.sv
tb/irq_least_count_balancer_tb.sv
